// ===== hw/rtl/thermistor_adc_to_temperature_core_defines.svh =====
// ----------------------------------------------------------------------------
// thermistor adc to temperature core: assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TADC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TADC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TADC_ASSERT_IMP(lbl, ante, cons, msg)
`define TADC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tadc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadc_pkg
// constants, calibration table and beat types for the thermistor converter
// ----------------------------------------------------------------------------
package tadc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int CODE_W    = 12;
    localparam int TEMP_W    = 16;

    // resistance = CTRL_OHMS * ADC_SPAN / code
    localparam int CTRL_OHMS = 10000;
    localparam int ADC_SPAN  = 1 << CODE_W;
    localparam int DIVIDEND  = CTRL_OHMS * ADC_SPAN;
    localparam int Q1_W      = $clog2(DIVIDEND + 1);
    localparam logic [Q1_W-1:0] DIVIDEND_BITS = Q1_W'(DIVIDEND);

    localparam int DIV1_STAGES = 4;
    localparam int DIV1_STEPS  = (Q1_W + DIV1_STAGES - 1) / DIV1_STAGES;

    // calibration table
    localparam int POINTS = 15;
    localparam int SEGS   = POINTS - 1;
    localparam int SEG_W  = $clog2(POINTS);
    localparam int OHMS_W = 21;
    localparam int DIFF_W = 20;
    localparam int TTBL_W = 8;
    localparam int DT_W   = 4;

    localparam logic [OHMS_W-1:0] TBL_OHMS [POINTS] = '{
        21'd1733200, 21'd959000, 21'd551410, 21'd327240, 21'd199990,
        21'd125250,  21'd100000, 21'd81000,  21'd53500,  21'd35900,
        21'd25000,   21'd17550,  21'd12540,  21'd9100,   21'd6710
    };

    localparam logic signed [TTBL_W-1:0] TBL_TEMP [POINTS] = '{
        -8'sd30, -8'sd20, -8'sd10, 8'sd0,  8'sd10, 8'sd20, 8'sd25, 8'sd30,
        8'sd40,  8'sd50,  8'sd60,  8'sd70, 8'sd80, 8'sd90, 8'sd100
    };

    // interpolation widths
    localparam int NUM_W = DT_W + DIFF_W + FRAC_BITS;
    localparam int Q2_W  = DT_W + FRAC_BITS;
    localparam int DIV2_STAGES = 2;
    localparam int DIV2_STEPS  = (Q2_W + DIV2_STAGES - 1) / DIV2_STAGES;
    localparam int SUM_W = TTBL_W + FRAC_BITS + 2;

    typedef struct packed {
        logic             ok;
        logic [SEG_W-1:0] seg;
        logic [NUM_W-1:0] num;
    } frac_req_t;

    typedef struct packed {
        logic             ok;
        logic [SEG_W-1:0] seg;
        logic [Q2_W-1:0]  frac;
    } frac_rsp_t;

    // resistance span of a segment
    function automatic logic [DIFF_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [OHMS_W-1:0] d;
        d = TBL_OHMS[seg] - TBL_OHMS[seg + 1'b1];
        return d[DIFF_W-1:0];
    endfunction

    // temperature step of a segment, always positive
    function automatic logic [DT_W-1:0] seg_dt(input logic [SEG_W-1:0] seg);
        logic signed [TTBL_W-1:0] d;
        d = TBL_TEMP[seg + 1'b1] - TBL_TEMP[seg];
        return d[DT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/thermistor_adc_to_temperature_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// adc code to resistance, table lookup and linear interpolation to degC/256
// ----------------------------------------------------------------------------
// pipeline stages: 4 reciprocal divider, 3 segment search / numerator,
//   2 fraction divider, 1 output register
// throughput: one beat per cycle while result_ready is high, set by the two pipelined dividers
// a stalled result only blocks input once all ten stages hold beats
// reset: rst_n clears every stage valid bit, payload registers are not reset
// ----------------------------------------------------------------------------
`include "thermistor_adc_to_temperature_core_defines.svh"

module thermistor_adc_to_temperature_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adc_valid,
    output logic                               adc_ready,
    input  logic [tadc_pkg::CODE_W-1:0]        adc_code,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               valid_res,
    output logic signed [tadc_pkg::TEMP_W-1:0] temperature
);
    import tadc_pkg::*;

    // saturation bounds of the 16-bit result
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (TEMP_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (TEMP_W - 1)));

    // expected output range for a valid beat (table ends, saturated)
    localparam int T_LO_RAW = TBL_TEMP[0] * (2 ** FRAC_BITS);
    localparam int T_HI_RAW = TBL_TEMP[POINTS-1] * (2 ** FRAC_BITS);
    localparam int T_LO = (T_LO_RAW < -(2 ** (TEMP_W - 1))) ? -(2 ** (TEMP_W - 1))
                                                          : T_LO_RAW;
    localparam int T_HI = (T_HI_RAW > 2 ** (TEMP_W - 1) - 1) ? 2 ** (TEMP_W - 1) - 1
                                                           : T_HI_RAW;

    // reciprocal divider -> segment stages
    logic              ohms_valid, ohms_ready;
    logic [Q1_W-1:0]   ohms;

    // segment stages -> fraction divider
    logic              req_valid, req_ready;
    frac_req_t         req;

    // fraction divider -> output register
    logic              rsp_valid;
    logic              out_en;
    frac_rsp_t         rsp;

    // output register
    logic                     out_v_reg;
    logic                     ok_reg, ok_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;

    logic signed [SUM_W-1:0]  base;
    logic signed [SUM_W-1:0]  sum;

    // resistance in ohms: 40960000 / code, one quotient digit per step
    tadc_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adc_valid),
        .in_ready  (adc_ready),
        .code      (adc_code),
        .out_valid (ohms_valid),
        .out_ready (ohms_ready),
        .ohms      (ohms)
    );

    // out-of-table resistance (including code zero) leaves req.ok low
    tadc_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ohms_valid),
        .in_ready  (ohms_ready),
        .ohms      (ohms),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .req       (req)
    );

    tadc_frac_div u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .req       (req),
        .out_valid (rsp_valid),
        .out_ready (out_en),
        .rsp       (rsp)
    );

    // output register takes a beat when empty or when the current one leaves
    assign out_en = !out_v_reg || result_ready;

    // base temperature of the segment plus interpolated fraction, saturated; zero when rsp.ok is low
    always_comb
    begin
        base = SUM_W'(TBL_TEMP[rsp.seg]);
        base = base <<< FRAC_BITS;
        sum  = base + SUM_W'($signed({1'b0, rsp.frac}));
        ok_next = rsp.ok;
        if (!rsp.ok) begin
            temp_next = '0;
        end
        else if (sum > SAT_HI) begin
            temp_next = SAT_HI[TEMP_W-1:0];
        end
        else if (sum < SAT_LO) begin
            temp_next = SAT_LO[TEMP_W-1:0];
        end
        else begin
            temp_next = sum[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end
        else if (out_en) begin
            out_v_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en) begin
            ok_reg   <= ok_next;
            temp_reg <= temp_next;
        end
    end

    assign result_valid = out_v_reg;
    assign valid_res    = ok_reg;
    assign temperature  = temp_reg;

    // out-of-range beats carry a zero temperature
    `TADC_ASSERT_IMP(a_invalid_is_zero, result_valid && !valid_res, temperature == '0, "invalid beat with nonzero temperature")

    // in-range beats stay within the table's temperature span
    `TADC_ASSERT_IMP(a_temp_in_span, result_valid && valid_res, (temperature >= TEMP_W'(T_LO)) && (temperature <= TEMP_W'(T_HI)), "temperature outside table span")

    // input backpressure only when the output beat is held
    `TADC_ASSERT_IMP(a_ready_only_when_held, !adc_ready, result_valid && !result_ready, "input stalled while output can drain")

    // a beat loaded from the divider shows up as a result next cycle
    `TADC_ASSERT_NXT(a_out_load, out_en && rsp_valid, result_valid && (valid_res == $past(rsp.ok)), "divider beat lost at output register")

endmodule

// ===== hw/rtl/tadc_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadc_recip
// pipelined restoring divider: constant dividend over the adc code
// ----------------------------------------------------------------------------
module tadc_recip (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tadc_pkg::CODE_W-1:0] code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tadc_pkg::Q1_W-1:0]   ohms
);
    import tadc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] rem;
        logic [Q1_W-1:0]   q;
    } div1_t;

    function automatic div1_t div1_stage(input div1_t cur, input int stage);
        div1_t           r;
        logic [CODE_W:0] trial;
        r = cur;
        for (int j = 0; j < DIV1_STEPS; j++) begin
            if (stage * DIV1_STEPS + j < Q1_W) begin
                trial = {r.rem, DIVIDEND_BITS[Q1_W-1-stage*DIV1_STEPS-j]};
                if (trial >= {1'b0, r.code}) begin
                    trial = trial - {1'b0, r.code};
                    r.q[Q1_W-1-stage*DIV1_STEPS-j] = 1'b1;
                end
                r.rem = trial[CODE_W-1:0];
            end
        end
        return r;
    endfunction

    logic [DIV1_STAGES-1:0] v_reg;
    logic [DIV1_STAGES:0]   en;
    div1_t                  st_reg  [DIV1_STAGES];
    div1_t                  st_next [DIV1_STAGES];
    div1_t                  st_in   [DIV1_STAGES];

    // a stage takes a new beat when empty or when its successor moves
    always_comb
    begin
        en[DIV1_STAGES] = out_ready;
        for (int s = DIV1_STAGES - 1; s >= 0; s--) begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_comb
    begin
        st_in[0] = '{code: code, rem: '0, q: '0};
        for (int s = 1; s < DIV1_STAGES; s++) begin
            st_in[s] = st_reg[s-1];
        end
        for (int s = 0; s < DIV1_STAGES; s++) begin
            st_next[s] = div1_stage(st_in[s], s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < DIV1_STAGES; s++) begin
                if (en[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV1_STAGES; s++) begin
            if (en[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DIV1_STAGES-1];
    assign ohms      = st_reg[DIV1_STAGES-1].q;

endmodule

// ===== hw/rtl/tadc_seg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadc_seg
// segment search, offset into segment and scaled interpolation numerator
// ----------------------------------------------------------------------------
module tadc_seg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tadc_pkg::Q1_W-1:0]  ohms,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tadc_pkg::frac_req_t        req
);
    import tadc_pkg::*;

    logic              a_v_reg, b_v_reg, c_v_reg;
    logic              a_en, b_en, c_en;

    logic              a_ok_reg, a_ok_next;
    logic [SEG_W-1:0]  a_seg_reg, a_seg_next;
    logic [OHMS_W-1:0] a_ohms_reg;

    logic              b_ok_reg;
    logic [SEG_W-1:0]  b_seg_reg;
    logic [DIFF_W-1:0] b_diff_reg, b_diff_next;
    logic [DT_W-1:0]   b_dt_reg;

    frac_req_t         c_req_reg, c_req_next;

    logic [OHMS_W-1:0]      b_sub;
    logic [DT_W+DIFF_W-1:0] c_prod;

    assign c_en     = !c_v_reg || out_ready;
    assign b_en     = !b_v_reg || c_en;
    assign a_en     = !a_v_reg || b_en;
    assign in_ready = a_en;

    // first matching segment wins on a shared boundary point
    always_comb
    begin
        a_ok_next  = 1'b0;
        a_seg_next = '0;
        for (int i = SEGS - 1; i >= 0; i--) begin
            if (ohms <= Q1_W'(TBL_OHMS[i]) && ohms >= Q1_W'(TBL_OHMS[i+1])) begin
                a_ok_next  = 1'b1;
                a_seg_next = SEG_W'(i);
            end
        end
    end

    always_comb
    begin
        b_sub       = TBL_OHMS[a_seg_reg] - a_ohms_reg;
        b_diff_next = b_sub[DIFF_W-1:0];
    end

    always_comb
    begin
        c_prod         = (DT_W+DIFF_W)'(b_dt_reg) * (DT_W+DIFF_W)'(b_diff_reg);
        c_req_next.ok  = b_ok_reg;
        c_req_next.seg = b_seg_reg;
        c_req_next.num = NUM_W'(c_prod) << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else begin
            if (a_en) begin
                a_v_reg <= in_valid;
            end
            if (b_en) begin
                b_v_reg <= a_v_reg;
            end
            if (c_en) begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en) begin
            a_ok_reg   <= a_ok_next;
            a_seg_reg  <= a_seg_next;
            a_ohms_reg <= ohms[OHMS_W-1:0];
        end
        if (b_en) begin
            b_ok_reg   <= a_ok_reg;
            b_seg_reg  <= a_seg_reg;
            b_diff_reg <= b_diff_next;
            b_dt_reg   <= seg_dt(a_seg_reg);
        end
        if (c_en) begin
            c_req_reg <= c_req_next;
        end
    end

    assign out_valid = c_v_reg;
    assign req       = c_req_reg;

endmodule

// ===== hw/rtl/tadc_frac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadc_frac_div
// pipelined restoring divider: numerator over the segment span
// ----------------------------------------------------------------------------
module tadc_frac_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tadc_pkg::frac_req_t req,
    output logic                out_valid,
    input  logic                out_ready,
    output tadc_pkg::frac_rsp_t rsp
);
    import tadc_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [SEG_W-1:0]  seg;
        logic [NUM_W-1:0]  num;
        logic [DIFF_W-1:0] rem;
        logic [Q2_W-1:0]   q;
    } div2_t;

    function automatic div2_t div2_stage(input div2_t cur, input int stage);
        div2_t             r;
        logic [DIFF_W:0]   trial;
        logic [DIFF_W-1:0] span;
        r    = cur;
        span = seg_span(cur.seg);
        for (int j = 0; j < DIV2_STEPS; j++) begin
            if (stage * DIV2_STEPS + j < Q2_W) begin
                trial = {r.rem, r.num[Q2_W-1-stage*DIV2_STEPS-j]};
                if (trial >= {1'b0, span}) begin
                    trial = trial - {1'b0, span};
                    r.q[Q2_W-1-stage*DIV2_STEPS-j] = 1'b1;
                end
                r.rem = trial[DIFF_W-1:0];
            end
        end
        return r;
    endfunction

    logic [DIV2_STAGES-1:0] v_reg;
    logic [DIV2_STAGES:0]   en;
    div2_t                  st_reg  [DIV2_STAGES];
    div2_t                  st_next [DIV2_STAGES];
    div2_t                  st_in   [DIV2_STAGES];

    always_comb
    begin
        en[DIV2_STAGES] = out_ready;
        for (int s = DIV2_STAGES - 1; s >= 0; s--) begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    // upper numerator bits seed the remainder; quotient fits in Q2_W bits
    always_comb
    begin
        st_in[0] = '{ok: req.ok, seg: req.seg, num: req.num,
                     rem: req.num[NUM_W-1:Q2_W], q: '0};
        for (int s = 1; s < DIV2_STAGES; s++) begin
            st_in[s] = st_reg[s-1];
        end
        for (int s = 0; s < DIV2_STAGES; s++) begin
            st_next[s] = div2_stage(st_in[s], s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < DIV2_STAGES; s++) begin
                if (en[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV2_STAGES; s++) begin
            if (en[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DIV2_STAGES-1];
    assign rsp.ok    = st_reg[DIV2_STAGES-1].ok;
    assign rsp.seg   = st_reg[DIV2_STAGES-1].seg;
    assign rsp.frac  = st_reg[DIV2_STAGES-1].q;

endmodule

// ===== tb/thermistor_temperature_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_temperature_checker
// watches both channels, predicts each reading and compares it in beat order
// ----------------------------------------------------------------------------
module thermistor_temperature_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adc_valid,
    input  logic                               adc_ready,
    input  logic [tadc_pkg::CODE_W-1:0]        adc_code,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic                               valid_res,
    input  logic signed [tadc_pkg::TEMP_W-1:0] temperature,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 checked,
    output int                                 in_range
);
    import tadc_pkg::*;

    localparam longint unsigned SENSE_OHMS = 10000;
    localparam longint unsigned CODE_SPAN  = 4096;
    localparam int              CURVE_PTS  = 15;
    localparam longint          TEMP_HI    = 32767;
    localparam longint          TEMP_LO    = -32768;
    localparam int              MAX_REPORTS = 40;

    // resistance falls while temperature rises
    localparam int unsigned CURVE_OHMS [CURVE_PTS] = '{
        1733200, 959000, 551410, 327240, 199990, 125250, 100000, 81000,
        53500, 35900, 25000, 17550, 12540, 9100, 6710
    };
    localparam int CURVE_DEGC [CURVE_PTS] = '{
        -30, -20, -10, 0, 10, 20, 25, 30, 40, 50, 60, 70, 80, 90, 100
    };

    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic                     in_range;
        logic signed [TEMP_W-1:0] degc_q;
    } reading_t;

    reading_t expected_readings [$];
    reading_t head;
    int       err_total  = 0;
    int       done_total = 0;
    int       hit_total  = 0;

    function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
        reading_t          r;
        longint unsigned   ohms;
        longint unsigned   upper;
        longint unsigned   lower;
        longint unsigned   step;
        longint unsigned   frac;
        longint            degc;
        int                i;
        r.code     = code;
        r.in_range = 1'b0;
        degc       = 0;
        if (code != '0) begin
            ohms = (SENSE_OHMS * CODE_SPAN) / longint'(code);
            // first segment wins on a shared end point
            for (i = 0; i < CURVE_PTS - 1; i++) begin
                upper = CURVE_OHMS[i];
                lower = CURVE_OHMS[i + 1];
                if (!r.in_range && ohms <= upper && ohms >= lower) begin
                    step = longint'(CURVE_DEGC[i + 1] - CURVE_DEGC[i]);
                    frac = ((step << FRAC_BITS) * (upper - ohms)) / (upper - lower);
                    degc = longint'(CURVE_DEGC[i]) * (longint'(1) << FRAC_BITS)
                           + longint'(frac);
                    r.in_range = 1'b1;
                end
            end
        end
        if (degc > TEMP_HI)
            degc = TEMP_HI;
        if (degc < TEMP_LO)
            degc = TEMP_LO;
        r.degc_q = degc[TEMP_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_readings.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    err_total++;
                    if (err_total <= MAX_REPORTS)
                        $display("%0t: unexpected result beat, got valid_res %0b temperature %0d",
                                 $realtime, valid_res, temperature);
                end
                else
                begin
                    head = expected_readings.pop_front();
                    done_total++;
                    if (head.in_range)
                        hit_total++;
                    if (valid_res !== head.in_range)
                    begin
                        err_total++;
                        if (err_total <= MAX_REPORTS)
                            $display("%0t: valid_res for code %0d, expected %0b, got %0b",
                                     $realtime, head.code, head.in_range, valid_res);
                    end
                    if (temperature !== head.degc_q)
                    begin
                        err_total++;
                        if (err_total <= MAX_REPORTS)
                            $display("%0t: temperature for code %0d, expected %0d, got %0d",
                                     $realtime, head.code, head.degc_q, temperature);
                    end
                end
            end
            if (adc_valid && adc_ready)
                expected_readings.push_back(predict_reading(adc_code));
        end
        mismatches <= err_total;
        pending    <= expected_readings.size();
        checked    <= done_total;
        in_range   <= hit_total;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives adc beats into the thermistor converter with random gaps and result
// stalls; a checker beside the block predicts and compares every reading
// ----------------------------------------------------------------------------
module testbench;
    import tadc_pkg::*;

    localparam int RANDOM_BEATS = 1130;
    localparam int DRAIN_AT     = 560;      // sender holds off here until all results are back
    localparam int SETTLE_CYC   = 24;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TOP_CODE     = (1 << CODE_W) - 1;
    localparam longint unsigned DIV_OHMS = 40960000;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      adc_valid    = 1'b0;
    logic [CODE_W-1:0]         adc_code     = '0;
    logic                      result_ready = 1'b0;
    logic                      adc_ready;
    logic                      result_valid;
    logic                      valid_res;
    logic signed [TEMP_W-1:0]  temperature;

    int mismatches;
    int pending;
    int checked;
    int in_range;

    int cycle_count = 0;
    int beats_sent  = 0;
    int stall_left  = 0;
    int calm_left   = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    thermistor_adc_to_temperature_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .adc_valid    (adc_valid),
        .adc_ready    (adc_ready),
        .adc_code     (adc_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .valid_res    (valid_res),
        .temperature  (temperature)
    );

    thermistor_temperature_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .adc_valid    (adc_valid),
        .adc_ready    (adc_ready),
        .adc_code     (adc_code),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .valid_res    (valid_res),
        .temperature  (temperature),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .in_range     (in_range)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("thermistor_adc_to_temperature_core: mismatch");
            $finish;
        end
    end

    // result side back-pressure: calm stretches with ready held high,
    // otherwise random stalls, mostly short and now and then long
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (calm_left != 0)
        begin
            result_ready <= 1'b1;
            calm_left    <= calm_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:2]:   begin result_ready <= 1'b1; calm_left  <= $urandom_range(50, 300); end
                [3:27]:  begin result_ready <= 1'b0; stall_left <= $urandom_range(0, 2);    end
                [28:30]: begin result_ready <= 1'b0; stall_left <= $urandom_range(10, 60);  end
                default: result_ready <= 1'b1;
            endcase
        end
    end

    // present one adc beat and hold it until the block takes it;
    // valid is left high so a back-to-back beat needs no second assignment
    task automatic send_code(input logic [CODE_W-1:0] code);
        adc_valid <= 1'b1;
        adc_code  <= code;
        @(posedge clk);
        while (!adc_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // sender gap after a beat: mostly none, some short, a few long
    function automatic int gap_cycles(input int idx);
        int pick;
        pick = $urandom_range(0, 99);
        if ((idx % 250) < 50)
            return 0;                        // back-to-back burst
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random sample: mostly uniform, some deep in the open-circuit region
    // where the resistance leaves the table, some right at segment ends
    function automatic logic [CODE_W-1:0] random_code();
        int     pick;
        int     pt;
        longint c;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return CODE_W'($urandom_range(0, 30));
        if (pick < 12)
        begin
            pt = $urandom_range(0, POINTS - 3);
            c  = DIV_OHMS / longint'(TBL_OHMS[pt]) + longint'($urandom_range(0, 2));
            if (c > TOP_CODE)
                c = TOP_CODE;
            return CODE_W'(c);
        end
        return CODE_W'($urandom_range(0, TOP_CODE));
    endfunction

    // drop valid for gap cycles, or wait for the pipeline to empty
    task automatic idle_sender(input int gap, input bit drain);
        if (drain)
        begin
            adc_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
        else if (gap > 0)
        begin
            adc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int     k;
        int     n_directed;
        longint c;
        logic [CODE_W-1:0] directed_codes [$];

        // reset held low from the start, then released once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero code, the open-circuit side of the table edge,
        // full scale, single bits, then for each reachable table point the
        // first code whose resistance falls below it
        directed_codes.push_back('0);
        directed_codes.push_back(CODE_W'(1));
        directed_codes.push_back(CODE_W'(23));
        directed_codes.push_back(CODE_W'(TOP_CODE));
        directed_codes.push_back(CODE_W'(TOP_CODE - 1));
        directed_codes.push_back(CODE_W'(1 << (CODE_W - 1)));
        for (k = 0; k < POINTS; k++)
        begin
            c = DIV_OHMS / longint'(TBL_OHMS[k]) + 1;
            if (c <= TOP_CODE)
                directed_codes.push_back(CODE_W'(c));
        end
        n_directed = directed_codes.size();

        foreach (directed_codes[i])
        begin
            send_code(directed_codes[i]);
            idle_sender(gap_cycles(i + 1), 1'b0);
        end
        // let the directed beats land before the random part
        idle_sender(0, 1'b1);

        for (k = 0; k < RANDOM_BEATS; k++)
        begin
            send_code(random_code());
            idle_sender(gap_cycles(k), k == DRAIN_AT);
        end

        // wait out every expected reading, then a little more for strays
        idle_sender(0, 1'b1);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("sent %0d adc beats (%0d directed), checked %0d readings, %0d inside the table",
                 beats_sent, n_directed, checked, in_range);
        if (mismatches == 0)
            $display("thermistor_adc_to_temperature_core: match");
        else
            $display("thermistor_adc_to_temperature_core: mismatch");
        $finish;
    end

endmodule
